// File: hdl/gf256_erasure_encoder_assert.svh
// Assertion macros for the GF(2^8) erasure encoder.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef GF256_ERASURE_ENCODER_ASSERT_SVH
`define GF256_ERASURE_ENCODER_ASSERT_SVH

// cond in this cycle implies nxt in the following cycle
`define GFEE_ASSERT_NEXT(label, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("gf256_erasure_encoder: check failed");

// cond implies same-cycle consequence
`define GFEE_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("gf256_erasure_encoder: check failed");

`endif

// File: hdl/gfee_pkg.sv
// Shared types, constants and the GF(2^8) multiply for the erasure encoder.
// No dependencies.
package gfee_pkg;

  localparam int SHARD_SLOTS = 8;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [1:0] REG_FIELD_POLY   = 2'd0;
  localparam logic [1:0] REG_DATA_COUNT   = 2'd1;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

  localparam logic [8:0] FIELD_POLY_RESET   = 9'h11D;
  localparam logic [3:0] DATA_COUNT_RESET   = 4'd8;
  localparam logic [3:0] OUTPUT_COUNT_RESET = 4'd8;

  localparam logic [8:0] GF_CARRY  = 9'h100;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  coeff_row;
    logic [2:0]  coeff_col;
    logic [7:0]  coeff_value;
    logic [63:0] data_bytes;
    logic        last_column;
  } in_word_t;

  typedef struct packed {
    logic [63:0] coded_bytes;
    logic        last_column_out;
  } out_word_t;

  // control of the lane stage handed to the merge stage
  typedef struct packed {
    logic valid;
    logic advance;
    logic last;
  } stage_ctl_t;

  // shift-and-add product; x^8 is folded in as the low byte of the polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = '0;
    for (int bit_i = 0; bit_i < 8; bit_i++) begin
      if (b[bit_i]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if ((x & GF_CARRY) != 9'h000) begin
        x = {1'b0, (x[7:0] & BYTE_MASK) ^ red};
      end
    end
    return acc;
  endfunction

endpackage

// File: hdl/gf256_erasure_encoder.sv
// GF(2^8) erasure encoder: coded row i = XOR over j of coeff[i][j] * data[j].
// An encode word is accepted, registered, run through all row lanes in
// parallel and lands in the output register.
// One word per cycle unless stalled; a load word updates the matrix and gives no result.
// Reset (synchronous, active high) clears the pipeline valids and restores the
// registers to 0x11D / 8 / 8; the coefficient matrix is undefined until written.
module gf256_erasure_encoder #(
  parameter int MAX_DATA_SHARDS = 8,
  parameter int MAX_OUT_SHARDS  = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  gfee_pkg::in_word_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output gfee_pkg::out_word_t result
);

  `include "gf256_erasure_encoder_assert.svh"

  logic [8:0]  field_polynomial;
  logic [3:0]  data_count;
  logic [3:0]  output_count;
  logic [3:0]  k_eff;
  logic [3:0]  n_eff;

  logic        advance;
  logic        accept;
  logic        a_valid;
  logic [63:0] a_data;
  logic        a_last;

  logic [7:0]  coeffs     [MAX_OUT_SHARDS][MAX_DATA_SHARDS];
  logic [7:0]  data_lane  [MAX_DATA_SHARDS];
  logic [7:0]  lane_bytes [gfee_pkg::SHARD_SLOTS];
  gfee_pkg::stage_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_polynomial <= gfee_pkg::FIELD_POLY_RESET;
      data_count       <= gfee_pkg::DATA_COUNT_RESET;
      output_count     <= gfee_pkg::OUTPUT_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gfee_pkg::REG_FIELD_POLY:   field_polynomial <= cfg_data;
        gfee_pkg::REG_DATA_COUNT:   data_count       <= cfg_data[3:0];
        gfee_pkg::REG_OUTPUT_COUNT: output_count     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign k_eff = (data_count > 4'(MAX_DATA_SHARDS)) ? 4'(MAX_DATA_SHARDS) : data_count;
  assign n_eff = (output_count > 4'(MAX_OUT_SHARDS)) ? 4'(MAX_OUT_SHARDS) : output_count;

  // whole pipeline moves when the output register is free or being drained
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= item_valid && item.opcode == gfee_pkg::OP_ENCODE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.opcode == gfee_pkg::OP_ENCODE) begin
      a_data <= item.data_bytes;
      a_last <= item.last_column;
    end
  end

  gfee_coeff_store #(
    .ROWS (MAX_OUT_SHARDS),
    .COLS (MAX_DATA_SHARDS)
  ) u_store (
    .clk    (clk),
    .we     (accept && item.opcode == gfee_pkg::OP_LOAD),
    .row    (item.coeff_row),
    .col    (item.coeff_col),
    .value  (item.coeff_value),
    .coeffs (coeffs)
  );

  for (genvar j = 0; j < MAX_DATA_SHARDS; j++) begin : g_data
    assign data_lane[j] = a_data[8*j +: 8];
  end

  for (genvar i = 0; i < gfee_pkg::SHARD_SLOTS; i++) begin : g_lane
    if (i < MAX_OUT_SHARDS) begin : g_used
      gfee_lane #(
        .COLS (MAX_DATA_SHARDS)
      ) u_lane (
        .coeffs   (coeffs[i]),
        .data     (data_lane),
        .k        (k_eff),
        .red      (field_polynomial[7:0]),
        .row_byte (lane_bytes[i])
      );
    end else begin : g_unused
      assign lane_bytes[i] = '0;
    end
  end

  assign ctl.valid   = a_valid;
  assign ctl.advance = advance;
  assign ctl.last    = a_last;

  gfee_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .n            (n_eff),
    .lane_bytes   (lane_bytes),
    .result       (result),
    .result_valid (result_valid)
  );

  `GFEE_ASSERT_NEXT(a_encode_enters, accept && item.opcode == gfee_pkg::OP_ENCODE, a_valid)
  `GFEE_ASSERT_NEXT(a_load_no_result, accept && item.opcode == gfee_pkg::OP_LOAD, !a_valid)
  `GFEE_ASSERT_NEXT(a_stage_to_output, a_valid && advance, result_valid)
  `GFEE_ASSERT_NEXT(a_stage_holds, a_valid && !advance, a_valid && $stable(a_data))

endmodule

// File: hdl/gfee_coeff_store.sv
// Coefficient matrix registers, one byte per row and column.
// Standalone; uses no package.
module gfee_coeff_store #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic       clk,
  input  logic       we,
  input  logic [2:0] row,
  input  logic [2:0] col,
  input  logic [7:0] value,
  output logic [7:0] coeffs [ROWS][COLS]
);

  logic [7:0] store [ROWS][COLS];

  // out-of-matrix writes match no entry and fall away
  for (genvar i = 0; i < ROWS; i++) begin : g_row
    for (genvar j = 0; j < COLS; j++) begin : g_col
      always_ff @(posedge clk) begin
        if (we && row == 3'(i) && col == 3'(j)) begin
          store[i][j] <= value;
        end
      end
      assign coeffs[i][j] = store[i][j];
    end
  end

endmodule

// File: hdl/gfee_lane.sv
// One output-row lane: GF products of the row coefficients with the first k data bytes, XORed.
// Depends on gfee_pkg (gf_mul).
module gfee_lane #(
  parameter int COLS = 8
) (
  input  logic [7:0] coeffs    [COLS],
  input  logic [7:0] data      [COLS],
  input  logic [3:0] k,
  input  logic [7:0] red,
  output logic [7:0] row_byte
);

  always_comb begin
    row_byte = '0;
    for (int j = 0; j < COLS; j++) begin
      if (4'(j) < k) begin
        row_byte = row_byte ^ gfee_pkg::gf_mul(coeffs[j], data[j], red);
      end
    end
  end

endmodule

// File: hdl/gfee_merge.sv
// Merge stage: packs lane bytes into the coded word and holds it in the output register.
// Depends on gfee_pkg (out_word_t, stage_ctl_t, SHARD_SLOTS).
module gfee_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  gfee_pkg::stage_ctl_t  ctl,
  input  logic [3:0]            n,
  input  logic [7:0]            lane_bytes [gfee_pkg::SHARD_SLOTS],
  output gfee_pkg::out_word_t   result,
  output logic                  result_valid
);

  logic [63:0] coded_next;

  always_comb begin
    coded_next = '0;
    for (int i = 0; i < gfee_pkg::SHARD_SLOTS; i++) begin
      if (4'(i) < n) begin
        coded_next[8*i +: 8] = lane_bytes[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.advance) begin
      result_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.valid) begin
      result.coded_bytes     <= coded_next;
      result.last_column_out <= ctl.last;
    end
  end

endmodule

// File: sim/gf256_erasure_encoder_test.sv
// Self-checking testbench for the GF(2^8) erasure encoder: coefficient loads feed a
// local GF(2^8) predictor, and encoded columns are checked word by word against it.
// Depends on gfee_pkg and gf256_erasure_encoder.
`timescale 1ns / 100ps

module gf256_erasure_encoder_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_WORDS    = 45;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [8:0]          cfg_data;
  logic                item_valid;
  logic                item_ready;
  gfee_pkg::in_word_t  item;
  logic                result_valid;
  logic                result_ready = 1'b0;
  gfee_pkg::out_word_t result;

  // block settings as last written
  logic [8:0]  poly_cfg;
  logic [3:0]  dcount_cfg;
  logic [3:0]  ocount_cfg;

  logic [7:0]  coeff_mirror [8][8];
  bit          loaded [8][8];
  gfee_pkg::out_word_t pending_columns [$];

  logic        rx_hold_req = 1'b0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int fail_count   = 0;
  int quiet_cycles = 0;

  gf256_erasure_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int active_count(input logic [3:0] c);
    return (c > gfee_pkg::SHARD_SLOTS) ? gfee_pkg::SHARD_SLOTS : int'(c);
  endfunction

  // Horner form, MSB first; x^8 folds into the low byte of the polynomial
  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] red);
    logic [7:0] p;
    p = '0;
    for (int i = 7; i >= 0; i--) begin
      p = {p[6:0], 1'b0} ^ (p[7] ? red : 8'h00);
      if (a[i]) begin
        p = p ^ b;
      end
    end
    return p;
  endfunction

  function automatic gfee_pkg::out_word_t predict_coding(input gfee_pkg::in_word_t w);
    gfee_pkg::out_word_t r;
    logic [7:0] acc;
    int         k;
    int         n;
    k = active_count(dcount_cfg);
    n = active_count(ocount_cfg);
    r.coded_bytes = '0;
    for (int i = 0; i < n; i++) begin
      acc = '0;
      for (int j = 0; j < k; j++) begin
        acc = acc ^ field_mul(coeff_mirror[i][j], w.data_bytes[8*j +: 8], poly_cfg[7:0]);
      end
      r.coded_bytes[8*i +: 8] = acc;
    end
    r.last_column_out = w.last_column;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : track_words
    gfee_pkg::out_word_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        if (item.opcode == gfee_pkg::OP_LOAD) begin
          coeff_mirror[item.coeff_row][item.coeff_col] = item.coeff_value;
        end else begin
          pending_columns.push_back(predict_coding(item));
        end
      end
      if (result_valid && result_ready) begin
        if (pending_columns.size() == 0) begin
          report_mismatch("unexpected result word", result.coded_bytes, '0);
        end else begin
          want = pending_columns.pop_front();
          if (result.coded_bytes !== want.coded_bytes) begin
            report_mismatch("coded_bytes", result.coded_bytes, want.coded_bytes);
          end
          if (result.last_column_out !== want.last_column_out) begin
            report_mismatch("last_column_out", 64'(result.last_column_out),
                            64'(want.last_column_out));
          end
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (rx_hold_req) begin
      result_ready <= 1'b0;
      rx_hold_left <= HOLD_CYCLES - 1;
    end else if (rx_hold_left > 0) begin
      result_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        tx_idle_pct = 0;  rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        tx_idle_pct = 58; rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct = 0;  rx_stall_pct = 58;
      end
      default: begin
        tx_idle_pct = 28; rx_stall_pct = 28;
      end
    endcase
  endtask

  // valid stays up across back-to-back words; it drops only during a gap or a drain
  task automatic send_word(input gfee_pkg::in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (!item_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [2:0] row, input logic [2:0] col,
                           input logic [7:0] value);
    gfee_pkg::in_word_t w;
    w.opcode      = gfee_pkg::OP_LOAD;
    w.coeff_row   = row;
    w.coeff_col   = col;
    w.coeff_value = value;
    w.data_bytes  = {$urandom, $urandom};
    w.last_column = 1'($urandom_range(1));
    send_word(w);
    loaded[row][col] = 1'b1;
  endtask

  // loads any coefficient the active matrix still lacks, then the column
  task automatic send_column(input logic [63:0] data, input logic last);
    gfee_pkg::in_word_t w;
    for (int r = 0; r < active_count(ocount_cfg); r++) begin
      for (int c = 0; c < active_count(dcount_cfg); c++) begin
        if (!loaded[r][c]) begin
          send_load(3'(r), 3'(c), 8'($urandom));
        end
      end
    end
    w.opcode      = gfee_pkg::OP_ENCODE;
    w.coeff_row   = 3'($urandom);
    w.coeff_col   = 3'($urandom);
    w.coeff_value = 8'($urandom);
    w.data_bytes  = data;
    w.last_column = last;
    send_word(w);
  endtask

  function automatic logic [63:0] rand_column();
    logic [63:0] d;
    d = {$urandom, $urandom};
    if ($urandom_range(3) == 0) begin
      for (int j = 0; j < gfee_pkg::SHARD_SLOTS; j++) begin
        case ($urandom_range(3))
          0: d[8*j +: 8] = 8'h00;
          1: d[8*j +: 8] = 8'hFF;
          2: d[8*j +: 8] = 8'h80;
          default: ;
        endcase
      end
    end
    return d;
  endfunction

  // the extra edge lets the checker log the last accepted column first
  task automatic wait_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_columns.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // upper cfg_data bits on count writes are junk and must be dropped
  task automatic configure(input logic [8:0] poly, input logic [3:0] dcount,
                           input logic [3:0] ocount);
    logic [4:0] junk;
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= gfee_pkg::REG_FIELD_POLY;
    cfg_data  <= poly;
    @(posedge clk);
    poly_cfg = poly;
    junk = 5'($urandom);
    cfg_index <= gfee_pkg::REG_DATA_COUNT;
    cfg_data  <= {junk, dcount};
    @(posedge clk);
    dcount_cfg = dcount;
    junk = 5'($urandom);
    cfg_index <= gfee_pkg::REG_OUTPUT_COUNT;
    cfg_data  <= {junk, ocount};
    @(posedge clk);
    ocount_cfg = ocount;
    if ($urandom_range(1) == 1) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= 9'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    set_idle(IDLE_NONE);
    configure(gfee_pkg::FIELD_POLY_RESET, 4'd1, 4'd1);
    send_load(3'd0, 3'd0, 8'h01);
    send_column(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_load(3'd0, 3'd0, 8'hFF);
    send_column(64'h0000_0000_0000_0080, 1'b1);
    send_column(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_load(3'd0, 3'd0, 8'h00);
    send_column(rand_column(), 1'b1);
    // corner entry, outside the active 1x1 matrix
    send_load(3'd7, 3'd7, 8'hA5);
    send_column(64'h0, 1'b0);
    // polynomial without the x^8 bit and with every bit set
    configure(9'h000, 4'd1, 4'd1);
    send_load(3'd0, 3'd0, 8'h80);
    send_column(64'h0000_0000_0000_0080, 1'b1);
    configure(9'h1FF, 4'd2, 4'd2);
    send_column(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    // no data shards: active rows are zero
    configure(gfee_pkg::FIELD_POLY_RESET, 4'd0, 4'd8);
    send_column(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // no output shards: whole word is zero
    configure(gfee_pkg::FIELD_POLY_RESET, 4'd8, 4'd0);
    send_column(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
  endtask

  task automatic test_random_phases();
    logic [8:0] poly;
    logic [3:0] dcount;
    logic [3:0] ocount;
    for (int p = 0; p < 14; p++) begin
      case (p)
        0: begin
          poly = gfee_pkg::FIELD_POLY_RESET; dcount = 4'd8;  ocount = 4'd8;
        end
        1: begin
          poly = 9'h100;           dcount = 4'd15; ocount = 4'd1;
        end
        2: begin
          poly = 9'h1FF;           dcount = 4'd1;  ocount = 4'd15;
        end
        3: begin
          poly = 9'h187;           dcount = 4'd8;  ocount = 4'd3;
        end
        default: begin
          poly   = 9'($urandom);
          dcount = 4'($urandom_range(15));
          ocount = 4'($urandom_range(15));
        end
      endcase
      configure(poly, dcount, ocount);
      set_idle(idle_mode_t'(p % 4));
      repeat (PHASE_WORDS) begin
        if ($urandom_range(3) == 0) begin
          send_load(3'($urandom), 3'($urandom), 8'($urandom));
        end else begin
          send_column(rand_column(), $urandom_range(7) == 0);
        end
      end
    end
  endtask

  // receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_receiver_hold();
    configure(gfee_pkg::FIELD_POLY_RESET, 4'd8, 4'd8);
    set_idle(IDLE_NONE);
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
    repeat (40) send_column(rand_column(), 1'($urandom_range(1)));
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = gfee_pkg::REG_FIELD_POLY;
    cfg_data   = '0;
    item_valid = 1'b0;
    item       = '0;
    poly_cfg   = gfee_pkg::FIELD_POLY_RESET;
    dcount_cfg = gfee_pkg::DATA_COUNT_RESET;
    ocount_cfg = gfee_pkg::OUTPUT_COUNT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phases();
    test_receiver_hold();
    wait_drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
